// ===== rtl/adam_pkg.sv =====
// Shared constants for the Adam optimizer update block.
package adam_pkg;

  localparam int ELEMENTS_DEFAULT = 4096;

  localparam int IDX_W   = 12;
  localparam int DATA_W  = 32;
  localparam int TDATA_W = 80;
  localparam int TUSER_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int EPS_W     = 16;

  localparam logic [31:0] STEP_SIZE_RST    = 32'd42949673;
  localparam logic [31:0] FIRST_DECAY_RST  = 32'd3865470566;
  localparam logic [31:0] SECOND_DECAY_RST = 32'd4290672329;
  localparam logic [15:0] STABILIZER_RST   = 16'd43;

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DECAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DECAY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STABILIZER   = 2'd3;

endpackage

// ===== rtl/adam_ram.sv =====
// Single-port RAM with registered read.
module adam_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = adam_pkg::ELEMENTS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/adam_optimizer_update.sv =====
// Adam optimizer update: moments, bias correction, root and step per element.
// After reset a clearing pass writes zero moments, one entry a cycle.
// From input transfer to valid result: a RAM read, multiply steps on the
// shared 33x33 multiplier, up to three divider passes, 32 root steps and control states.
// One item at a time; next item taken once the result transfers.
// Synchronous active-high reset restores registers, powers and step counter.
module adam_optimizer_update #(
  parameter int ELEMENTS = adam_pkg::ELEMENTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [11:0] elem_index, [43:12] gradient, [75:44] position, [79:76] zero
  input  logic [adam_pkg::TDATA_W-1:0]   s_axis_tdata,
  // [0] step_start, [1] run_start
  input  logic [adam_pkg::TUSER_W-1:0]   s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [11:0] out_index, [43:12] new_position, [75:44] step_update, [79:76] zero
  output logic [adam_pkg::TDATA_W-1:0]   m_axis_tdata,
  input  logic                           cfg_we,
  input  logic [adam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [adam_pkg::CFG_W-1:0]     cfg_data
);

  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int RW = 96;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_MUL, S_WB, S_DIVM, S_BV, S_DIVV,
    S_SQI, S_SQRT, S_NUM, S_NUMW, S_DIVQ, S_FIN, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_P1, OP_P2, OP_MB, OP_MG, OP_GG, OP_VL, OP_VH, OP_GL, OP_GH, OP_AN
  } mul_op_t;

  state_t  state;
  mul_op_t mop;
  logic    mphase;

  logic [AW-1:0] clr_addr;
  logic [31:0]   alpha, beta1, beta2;
  logic [15:0]   eps;
  logic [31:0]   step_count;
  logic [32:0]   pow1, pow2;

  logic [11:0] it_idx;
  logic [31:0] it_g, it_pos;
  logic        it_ss, it_rs, it_valid;
  logic [31:0] m_old;
  logic [63:0] v_old;

  logic [65:0]        prod;
  logic signed [65:0] acc_m;
  logic [96:0]        acc_v;
  logic [63:0]        g2;

  logic        mneg;
  logic [63:0] v_new_r;
  logic [31:0] mag_t;
  logic [31:0] qfin;
  logic [48:0] den;

  logic [48:0] drem, dden;
  logic [63:0] dquo;
  logic [6:0]  dcnt;

  logic [63:0] sx, sres;
  logic [4:0]  scnt;

  logic [adam_pkg::TDATA_W-1:0] out_data;
  logic                          out_valid;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  adam_ram #(.WIDTH(RW), .DEPTH(ELEMENTS)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // operand and datapath logic
  logic        g_neg, mo_neg;
  logic [31:0] g_mag, mo_mag;
  logic [32:0] omb1, omb2, d1, d2;
  logic [32:0] mul_a, mul_b;
  logic signed [65:0] sp, msum;
  logic [96:0] vsum;
  logic [31:0] m_new, mag_m, lim;
  logic [63:0] v_new;
  logic [50:0] tsub;
  logic        dok, drnd;
  logic [63:0] dq_r;
  logic [63:0] bitv, strial;
  logic [48:0] den_c;
  logic signed [32:0] upd;
  logic signed [33:0] np;
  logic [31:0] np_sat;

  always_comb begin
    g_neg  = it_g[31];
    g_mag  = g_neg ? (~it_g + 32'd1) : it_g;
    mo_neg = m_old[31];
    mo_mag = mo_neg ? (~m_old + 32'd1) : m_old;
    omb1   = adam_pkg::ONE_Q32 - {1'b0, beta1};
    omb2   = adam_pkg::ONE_Q32 - {1'b0, beta2};
    d1     = adam_pkg::ONE_Q32 - pow1;
    d2     = adam_pkg::ONE_Q32 - pow2;
    case (mop)
      OP_P1:   begin mul_a = pow1;                 mul_b = {1'b0, beta1}; end
      OP_P2:   begin mul_a = pow2;                 mul_b = {1'b0, beta2}; end
      OP_MB:   begin mul_a = {1'b0, beta1};        mul_b = {1'b0, mo_mag}; end
      OP_MG:   begin mul_a = omb1;                 mul_b = {1'b0, g_mag}; end
      OP_GG:   begin mul_a = {1'b0, g_mag};        mul_b = {1'b0, g_mag}; end
      OP_VL:   begin mul_a = {1'b0, v_old[31:0]};  mul_b = {1'b0, beta2}; end
      OP_VH:   begin mul_a = {1'b0, v_old[63:32]}; mul_b = {1'b0, beta2}; end
      OP_GL:   begin mul_a = {1'b0, g2[31:0]};     mul_b = omb2; end
      OP_GH:   begin mul_a = {1'b0, g2[63:32]};    mul_b = omb2; end
      OP_AN:   begin mul_a = {1'b0, alpha};        mul_b = {1'b0, mag_t}; end
      default: begin mul_a = '0;                   mul_b = '0; end
    endcase
    sp    = $signed(prod);
    msum  = acc_m + 66'sh8000_0000;
    m_new = msum[63:32];
    mag_m = m_new[31] ? (~m_new + 32'd1) : m_new;
    vsum  = acc_v + 97'h8000_0000;
    v_new = vsum[95:32];
    lim   = mneg ? 32'h8000_0000 : 32'h7FFF_FFFF;

    tsub = {1'b0, drem, dquo[63]} - {2'b00, dden};
    dok  = !tsub[50];
    drnd = ({drem, 1'b0} >= {1'b0, dden});
    dq_r = (drnd && !(&dquo)) ? dquo + 64'd1 : dquo;

    bitv   = 64'd1 << {scnt, 1'b0};
    strial = sres + bitv;
    den_c  = {1'b0, sres[31:0], 16'h0000} + {33'd0, eps};

    upd    = mneg ? -$signed({1'b0, qfin}) : $signed({1'b0, qfin});
    np     = $signed({{2{it_pos[31]}}, it_pos}) - {upd[32], upd};
    if (np > 34'sh0_7FFF_FFFF) np_sat = 32'h7FFF_FFFF;
    else if (np < -34'sh0_8000_0000) np_sat = 32'h8000_0000;
    else np_sat = np[31:0];

    ram_we    = (state == S_CLEAR) || ((state == S_WB) && it_valid);
    ram_wdata = (state == S_CLEAR) ? '0 : {v_new, m_new};
    case (state)
      S_CLEAR: ram_addr = clr_addr;
      S_IDLE:  ram_addr = AW'(s_axis_tdata[11:0]);
      default: ram_addr = AW'(it_idx);
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      alpha      <= adam_pkg::STEP_SIZE_RST;
      beta1      <= adam_pkg::FIRST_DECAY_RST;
      beta2      <= adam_pkg::SECOND_DECAY_RST;
      eps        <= adam_pkg::STABILIZER_RST;
      step_count <= '0;
      pow1       <= adam_pkg::ONE_Q32;
      pow2       <= adam_pkg::ONE_Q32;
      out_valid  <= 1'b0;
      mop        <= OP_P1;
      mphase     <= 1'b0;
      dcnt       <= '0;
      scnt       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          adam_pkg::CFG_STEP_SIZE:    alpha <= cfg_data;
          adam_pkg::CFG_FIRST_DECAY:  beta1 <= cfg_data;
          adam_pkg::CFG_SECOND_DECAY: beta2 <= cfg_data;
          adam_pkg::CFG_STABILIZER:   eps   <= cfg_data[adam_pkg::EPS_W-1:0];
          default: ;
        endcase
      end

      // shared divider step
      if ((state == S_DIVM || state == S_DIVV || state == S_DIVQ) && dcnt != 7'd0) begin
        drem <= dok ? tsub[48:0] : {drem[47:0], dquo[63]};
        dquo <= {dquo[62:0], dok};
        dcnt <= dcnt - 7'd1;
      end

      case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(ELEMENTS - 1)) state <= S_IDLE;
          else clr_addr <= clr_addr + AW'(1);
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            it_idx   <= s_axis_tdata[11:0];
            it_g     <= s_axis_tdata[43:12];
            it_pos   <= s_axis_tdata[75:44];
            it_ss    <= s_axis_tuser[0];
            it_rs    <= s_axis_tuser[1];
            it_valid <= (32'(s_axis_tdata[11:0]) < ELEMENTS);
            state    <= S_READ;
          end
        end
        S_READ: begin
          if (it_valid && !it_rs) begin
            m_old <= ram_rdata[31:0];
            v_old <= ram_rdata[95:32];
          end else begin
            m_old <= '0;
            v_old <= '0;
          end
          mop    <= OP_P1;
          mphase <= 1'b0;
          state  <= S_MUL;
        end
        S_MUL: begin
          if (!mphase) begin
            mphase <= 1'b1;
          end else begin
            mphase <= 1'b0;
            mop    <= mul_op_t'(mop + 4'd1);
            case (mop)
              OP_P1: if (it_ss) pow1 <= 33'((prod + 66'h8000_0000) >> 32);
              OP_P2: begin
                if (it_ss) begin
                  pow2       <= 33'((prod + 66'h8000_0000) >> 32);
                  step_count <= step_count + 32'd1;
                end
              end
              OP_MB: acc_m <= mo_neg ? -sp : sp;
              OP_MG: acc_m <= g_neg ? acc_m - sp : acc_m + sp;
              OP_GG: g2 <= prod[63:0];
              OP_VL: acc_v <= 97'(prod);
              OP_VH: acc_v <= acc_v + (97'(prod) << 32);
              OP_GL: acc_v <= acc_v + 97'(prod);
              OP_GH: begin
                acc_v <= acc_v + (97'(prod) << 32);
                state <= S_WB;
              end
              default: ;
            endcase
          end
        end
        S_WB: begin
          mneg    <= m_new[31];
          v_new_r <= v_new;
          if (!pow1[32]) begin
            drem  <= '0;
            dquo  <= {mag_m, 32'h0};
            dden  <= 49'(d1);
            dcnt  <= 7'd64;
            state <= S_DIVM;
          end else begin
            mag_t <= mag_m;
            state <= S_BV;
          end
        end
        S_DIVM: begin
          if (dcnt == 7'd0) begin
            mag_t <= (dq_r > 64'(lim)) ? lim : dq_r[31:0];
            state <= S_BV;
          end
        end
        S_BV: begin
          if (mag_t > lim) mag_t <= lim;
          if (pow2[32]) begin
            sx    <= v_new_r;
            state <= S_SQI;
          end else if (33'(v_new_r[63:32]) >= d2) begin
            sx    <= '1;
            state <= S_SQI;
          end else begin
            drem  <= 49'(v_new_r[63:32]);
            dquo  <= {v_new_r[31:0], 32'h0};
            dden  <= 49'(d2);
            dcnt  <= 7'd64;
            state <= S_DIVV;
          end
        end
        S_DIVV: begin
          if (dcnt == 7'd0) begin
            sx    <= dq_r;
            state <= S_SQI;
          end
        end
        S_SQI: begin
          sres  <= '0;
          scnt  <= 5'd31;
          mop   <= OP_AN;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sx >= strial) begin
            sx   <= sx - strial;
            sres <= (sres >> 1) + bitv;
          end else begin
            sres <= sres >> 1;
          end
          scnt <= scnt - 5'd1;
          if (scnt == 5'd0) state <= S_NUM;
        end
        S_NUM: begin
          den <= den_c;
          if (den_c == 49'd0) begin
            qfin  <= (mag_t == 32'd0) ? 32'd0 : lim;
            state <= S_FIN;
          end else begin
            state <= S_NUMW;
          end
        end
        S_NUMW: begin
          drem  <= '0;
          dquo  <= prod[63:0] + 64'(den >> 1);
          dden  <= den;
          dcnt  <= 7'd64;
          state <= S_DIVQ;
        end
        S_DIVQ: begin
          if (dcnt == 7'd0) begin
            qfin  <= (dquo > 64'(lim)) ? lim : dquo[31:0];
            state <= S_FIN;
          end
        end
        S_FIN: begin
          out_data  <= {4'h0, upd[31:0], np_sat, it_idx};
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/adam_checker.sv =====
// Port-level checks for the Adam optimizer update block, bound to the top level.
module adam_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [adam_pkg::TDATA_W-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while result pending");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
    else $error("not busy after input transfer");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("repeated result after output transfer");

endmodule

bind adam_optimizer_update adam_checker u_adam_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ===== test/adam_optimizer_update_test.sv =====
// Testbench for adam_optimizer_update: scoreboard with an Adam step predictor, random traffic.
`timescale 1ns / 1ps

module adam_optimizer_update_test;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [adam_pkg::IDX_W-1:0] index;
    logic [31:0]                position;
    logic [31:0]                update;
  } step_result_t;

  class adam_scoreboard;
    int               first_mom [adam_pkg::ELEMENTS_DEFAULT];
    logic [63:0]      second_mom [adam_pkg::ELEMENTS_DEFAULT];
    logic [32:0]      pow1, pow2;
    logic [31:0]      alpha, beta1, beta2;
    logic [15:0]      eps;
    step_result_t     pending[$];
    int               errors;

    function new();
      foreach (first_mom[i]) begin
        first_mom[i] = 0;
        second_mom[i] = '0;
      end
      pow1 = adam_pkg::ONE_Q32;
      pow2 = adam_pkg::ONE_Q32;
      alpha = adam_pkg::STEP_SIZE_RST;
      beta1 = adam_pkg::FIRST_DECAY_RST;
      beta2 = adam_pkg::SECOND_DECAY_RST;
      eps = adam_pkg::STABILIZER_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [adam_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        adam_pkg::CFG_STEP_SIZE:    alpha = val;
        adam_pkg::CFG_FIRST_DECAY:  beta1 = val;
        adam_pkg::CFG_SECOND_DECAY: beta2 = val;
        adam_pkg::CFG_STABILIZER:   eps = val[15:0];
        default: ;
      endcase
    endfunction

    // round(num * 2^32 / d), saturated to 64 bits
    function logic [63:0] bias_div(logic [63:0] num, logic [32:0] d);
      logic [127:0] n, q, r;
      if ({64'd0, num[63:32]} >= {31'd0, d}) return '1;
      n = {32'd0, num, 32'd0};
      q = n / d;
      r = n % d;
      if (2 * r >= d && q[63:0] != '1) q = q + 1;
      return q[63:0];
    endfunction

    function logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > x) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
        if (x >= res + bit_w) begin
          x = x - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w = bit_w >> 2;
      end
      return res;
    endfunction

    function void note(logic [adam_pkg::IDX_W-1:0] idx, logic [31:0] grad, logic [31:0] pos,
                       logic step_start, logic run_start);
      logic signed [95:0] sb1, sc1, sm, sg, acc;
      logic [127:0] vw, wb2, wc2, wv, wg2;
      logic [65:0] pw;
      logic [63:0] gmag, v_old, v_new, mag, vt, den, num, q, lim;
      longint m_new, gs, upd, np;
      int m_old;
      logic neg, in_range;
      step_result_t r;
      in_range = idx < adam_pkg::ELEMENTS_DEFAULT;
      if (step_start) begin
        pw = pow1 * beta1 + 66'h8000_0000;
        pow1 = pw[64:32];
        pw = pow2 * beta2 + 66'h8000_0000;
        pow2 = pw[64:32];
      end
      m_old = 0;
      v_old = 0;
      if (in_range && !run_start) begin
        m_old = first_mom[idx];
        v_old = second_mom[idx];
      end
      gs = longint'($signed(grad));
      sb1 = beta1;
      sc1 = adam_pkg::ONE_Q32 - beta1;
      sm = m_old;
      sg = gs;
      acc = sb1 * sm + sc1 * sg + 96'sd2147483648;
      acc = acc >>> 32;
      m_new = acc[63:0];
      gmag = gs < 0 ? -gs : gs;
      wb2 = beta2;
      wc2 = adam_pkg::ONE_Q32 - beta2;
      wv = v_old;
      wg2 = gmag * gmag;
      vw = wb2 * wv + wc2 * wg2 + 128'h8000_0000;
      v_new = vw[95:32];
      if (in_range) begin
        first_mom[idx] = int'(m_new);
        second_mom[idx] = v_new;
      end
      neg = m_new < 0;
      mag = neg ? -m_new : m_new;
      if (pow1 < adam_pkg::ONE_Q32) mag = bias_div(mag, adam_pkg::ONE_Q32 - pow1);
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (mag > lim) mag = lim;
      vt = v_new;
      if (pow2 < adam_pkg::ONE_Q32) vt = bias_div(vt, adam_pkg::ONE_Q32 - pow2);
      den = (root_floor(vt) << 16) + eps;
      if (den == 0) begin
        q = (mag == 0) ? 0 : lim;
      end else begin
        num = alpha * mag;
        q = (num + den / 2) / den;
        if (q > lim) q = lim;
      end
      upd = neg ? -longint'(q) : longint'(q);
      np = longint'($signed(pos)) - upd;
      if (np > 64'sd2147483647) np = 64'sd2147483647;
      if (np < -64'sd2147483648) np = -64'sd2147483648;
      r.index = idx;
      r.position = np[31:0];
      r.update = upd[31:0];
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check(logic [adam_pkg::TDATA_W-1:0] data);
      step_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", data));
        return;
      end
      e = pending.pop_front();
      if (data[11:0] !== e.index)
        report($sformatf("out_index %h, want %h", data[11:0], e.index));
      if (data[43:12] !== e.position)
        report($sformatf("new_position %h, want %h (idx %h)", data[43:12], e.position, e.index));
      if (data[75:44] !== e.update)
        report($sformatf("step_update %h, want %h (idx %h)", data[75:44], e.update, e.index));
      if (data[79:76] !== 4'd0)
        report($sformatf("pad bits %h", data[79:76]));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [adam_pkg::TDATA_W-1:0] s_axis_tdata = '0;
  logic [adam_pkg::TUSER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [adam_pkg::TDATA_W-1:0] m_axis_tdata;
  logic cfg_we = 0;
  logic [adam_pkg::CFG_IDX_W-1:0] cfg_index = adam_pkg::CFG_STEP_SIZE;
  logic [adam_pkg::CFG_W-1:0] cfg_data = '0;

  adam_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int quiet = 0;

  adam_optimizer_update i_dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 0;
    else m_axis_tready <= $urandom_range(99) >= recv_stall;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task write_reg(logic [adam_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task set_all(logic [31:0] a, logic [31:0] b1, logic [31:0] b2, logic [15:0] e);
    write_reg(adam_pkg::CFG_STEP_SIZE, a);
    write_reg(adam_pkg::CFG_FIRST_DECAY, b1);
    write_reg(adam_pkg::CFG_SECOND_DECAY, b2);
    write_reg(adam_pkg::CFG_STABILIZER, {16'd0, e});
    cfg_we <= 0;
  endtask

  task send(logic [11:0] idx, logic [31:0] grad, logic [31:0] pos, logic ss, logic rs);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {4'd0, pos, grad, idx};
    s_axis_tuser <= {rs, ss};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note(idx, grad, pos, ss, rs);
  endtask

  task drain();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function logic [31:0] rand_q16();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(131071)) - 65536);
      2: return 32'($signed($urandom_range(2047)) - 1024);
      3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(33554431)) - 16777216);
    endcase
  endfunction

  // iterations over a small element block; a few noise items mixed in
  task random_items(int count);
    int sent, n, base, iters;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        send(12'($urandom), rand_q16(), rand_q16(), 1'($urandom), 1'($urandom));
        sent++;
      end else begin
        n = $urandom_range(1, 6);
        base = $urandom_range(adam_pkg::ELEMENTS_DEFAULT - n);
        iters = $urandom_range(1, 5);
        for (int it = 0; it < iters; it++)
          for (int k = 0; k < n; k++) begin
            send(12'(base + k), rand_q16(), rand_q16(), k == 0, it == 0);
            sent++;
          end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    // no step taken yet at first: bias correction skipped until the first step_start
    send(12'd0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    send(12'd4095, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    send(12'd0, 32'h0000_0000, 32'h0000_0000, 0, 0);
    send(12'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 1);
    send(12'd0, 32'h0001_0000, 32'h8000_0000, 1, 1);
    send(12'd4095, 32'hFFFF_0000, 32'h0000_0001, 0, 0);
    send(12'd0, 32'h8000_0000, 32'h8000_0000, 1, 0);
    send(12'd4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1);
    drain();
    // zero denominator: moment kept, second moment dropped, no epsilon
    set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 16'd0);
    send(12'd7, 32'h0010_0000, 32'h0000_0000, 1, 1);
    send(12'd7, 32'h0000_0000, 32'h0000_0000, 0, 0);
    send(12'd8, 32'h0000_0000, 32'h0000_1234, 0, 1);
    send(12'd7, 32'h8000_0000, 32'h8000_0000, 1, 0);
    send(12'd7, 32'h0000_0000, 32'h8000_0000, 0, 0);
    drain();
    set_all(32'd0, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
    send(12'd9, 32'h7FFF_FFFF, 32'h1234_5678, 1, 1);
    send(12'd9, 32'h8000_0000, 32'h8765_4321, 1, 0);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 51; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 51; end
        default: begin send_idle = 38; recv_stall = 38; end
      endcase
      case (ph)
        0: set_all(adam_pkg::STEP_SIZE_RST, adam_pkg::FIRST_DECAY_RST,
                   adam_pkg::SECOND_DECAY_RST, adam_pkg::STABILIZER_RST);
        1: set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        2: set_all(32'd0, 32'd0, 32'd0, 16'd0);
        3: set_all($urandom, $urandom, $urandom, 16'($urandom));
        4: set_all(32'h8000_0000, 32'hF000_0000, 32'hFFF0_0000, 16'd1);
        default: set_all($urandom, 32'hE000_0000 | $urandom, 32'hFF00_0000 | $urandom,
                         16'($urandom_range(255)));
      endcase
      random_items(135);
      drain();
    end
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== adam_optimizer_update.f =====
rtl/adam_pkg.sv
rtl/adam_ram.sv
rtl/adam_optimizer_update.sv
rtl/adam_checker.sv
test/adam_optimizer_update_test.sv
